/* rtl/gvr_pkg.sv */
// shared defaults for the givens rotation coefficient pipeline
package gvr_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 30;

endpackage

/* rtl/givens_rotation_coefficients_core.sv */
// top level: fully pipelined givens rotation cosine and sine generator
//
// Usage
//   s_* stream: one request per beat. s_tdata holds a_value in the low
//   DATA_WIDTH bits and b_value above it, both signed and on a common scale.
//   m_* stream: one result per request, in order. m_tdata holds cosine in the
//   low DATA_WIDTH bits and sine above it, both signed with FRAC_BITS
//   fraction bits.
//   cfg_wr_en / cfg_wr_data: writes the tolerance; a |b| below it gives c = 1,
//   s = 0. Write it only while the pipeline is empty.
// Throughput and structure
//   One request per cycle while m_tready does not stall the pipeline. The
//   depth comes from three digit-per-stage units in series: the ratio
//   divider (FRAC_BITS+2 stages), the square root (FRAC_BITS+1) and the
//   reciprocal divider (FRAC_BITS+2), plus the multiply and rounding stages
//   around them.
// Reset: rst clears every stage valid bit and sets the tolerance to 1
// Stall: while a result waits with m_tready low the whole pipeline holds and
//   s_tready is low; nothing is dropped or repeated.
module givens_rotation_coefficients_core #(
  parameter int unsigned DATA_WIDTH = gvr_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = gvr_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_wr_en,
  input  logic [DATA_WIDTH-2:0]                    cfg_wr_data,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // a_value, b_value, zero pad
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]        s_tdata,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // cosine, sine, zero pad
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]        m_tdata
);
  import gvr_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int QW  = F + 2;          // raw quotient width
  localparam int TW  = F + 1;          // ratio / coefficient width
  localparam int XW  = F + 2;          // 1 + t^2
  localparam int YW  = 2 * F + 2;      // radicand
  localparam int RW  = F + 3;          // root remainder
  localparam int PW  = ((2 * DW + 7) / 8) * 8;
  localparam int LAT    = 3 * F + 13;
  localparam logic [DW-1:0] ONE_OUT = DW'(64'd1 << F);

  logic          adv;
  logic [DW-2:0] tolerance;
  logic [LAT-1:0] vld, triv, swp, ng;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= (DW-1)'(1);
    end else if (cfg_wr_en) begin
      tolerance <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // input stage: magnitudes, path choice
  logic [DW-1:0] in_a, in_b, am, bm, num_in, den_in;
  logic          lt_tol, sw_in, trv_in;

  always_comb begin
    in_a   = s_tdata[DW-1:0];
    in_b   = s_tdata[2*DW-1:DW];
    am     = in_a[DW-1] ? (~in_a + DW'(1)) : in_a;
    bm     = in_b[DW-1] ? (~in_b + DW'(1)) : in_b;
    lt_tol = bm < {1'b0, tolerance};
    sw_in  = bm > am;
    trv_in = lt_tol || (am == '0 && bm == '0);
    num_in = sw_in ? am : bm;
    den_in = sw_in ? bm : am;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      triv <= {triv[LAT-2:0], trv_in};
      swp  <= {swp[LAT-2:0], sw_in};
      ng   <= {ng[LAT-2:0], in_a[DW-1] ^ in_b[DW-1]};
    end
  end

  // ratio divider, one quotient bit a stage
  logic [DW:0]   dv_r   [0:F+2];
  logic [DW-1:0] dv_den [0:F+2];
  logic [QW-1:0] dv_q   [0:F+2];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0]   <= {1'b0, num_in};
      dv_den[0] <= den_in;
      dv_q[0]   <= '0;
    end
  end

  genvar j;
  generate
    for (j = 0; j < F + 2; j++) begin : g_div
      logic [DW:0] rr;
      logic        ge;
      always_comb begin
        if (j == 0) begin
          rr = dv_r[j];
        end else begin
          rr = {dv_r[j][DW-1:0], 1'b0};
        end
        ge = rr >= {1'b0, dv_den[j]};
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_r[j+1]   <= ge ? (rr - {1'b0, dv_den[j]}) : rr;
          dv_den[j+1] <= dv_den[j];
          dv_q[j+1]   <= {dv_q[j][QW-2:0], ge};
        end
      end
    end
  endgenerate

  // round the ratio, square it, form 1 + t^2
  logic [TW-1:0]   t_t, t_sq_in;
  logic [2*TW-1:0] sq;
  logic [XW-1:0]   x_val;
  logic [YW-1:0]   sq_rnd;

  assign sq_rnd = sq + YW'(64'd1 << (F - 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      t_t     <= TW'(((QW+1)'(dv_q[F+2]) + (QW+1)'(1)) >> 1);
      sq      <= (2*TW)'(t_t) * (2*TW)'(t_t);
      t_sq_in <= t_t;
      x_val   <= XW'(64'd1 << F) + XW'(sq_rnd >> F);
    end
  end

  // square root, one root bit a stage
  logic [RW-1:0] sr_rem  [1:F+1];
  logic [TW-1:0] sr_root [1:F+1];
  logic [YW-1:0] sr_y    [1:F+1];
  logic [TW-1:0] sr_t    [0:F+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_t[0] <= t_sq_in;
    end
  end

  genvar k;
  generate
    for (k = 0; k < F + 1; k++) begin : g_sqrt
      logic [RW-1:0] rem_in, sh, trial;
      logic [TW-1:0] root_in;
      logic [YW-1:0] y_in;
      logic          ge;
      if (k == 0) begin : g_head
        assign rem_in  = '0;
        assign root_in = '0;
        assign y_in    = {x_val, F'(0)};
      end else begin : g_body
        assign rem_in  = sr_rem[k];
        assign root_in = sr_root[k];
        assign y_in    = sr_y[k];
      end
      always_comb begin
        sh    = {rem_in[RW-3:0], y_in[YW-1-2*k -: 2]};
        trial = {root_in, 2'b01};
        ge    = sh >= trial;
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          sr_rem[k+1]  <= ge ? (sh - trial) : sh;
          sr_root[k+1] <= {root_in[TW-2:0], ge};
          sr_y[k+1]    <= y_in;
          sr_t[k+1]    <= sr_t[k];
        end
      end
    end
  endgenerate

  // reciprocal divider: 2^(2F+1) / root, one bit a stage
  logic [F+1:0]  rc_rem [1:F+2];
  logic [TW-1:0] rc_den [1:F+2];
  logic [QW-1:0] rc_q   [1:F+2];
  logic [TW-1:0] rc_t   [1:F+2];

  genvar m;
  generate
    for (m = 0; m < F + 2; m++) begin : g_rcp
      logic [F+1:0]  rem_in, rr;
      logic [TW-1:0] den_in_r, t_in;
      logic [QW-1:0] q_in;
      logic          ge;
      if (m == 0) begin : g_head
        assign rem_in   = (F+2)'(64'd1 << (F - 1));
        assign den_in_r = sr_root[F+1];
        assign q_in     = '0;
        assign t_in     = sr_t[F+1];
      end else begin : g_body
        assign rem_in   = rc_rem[m];
        assign den_in_r = rc_den[m];
        assign q_in     = rc_q[m];
        assign t_in     = rc_t[m];
      end
      always_comb begin
        rr = {rem_in[F:0], 1'b0};
        ge = rr >= {1'b0, den_in_r};
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          rc_rem[m+1] <= ge ? (rr - {1'b0, den_in_r}) : rr;
          rc_den[m+1] <= den_in_r;
          rc_q[m+1]   <= {q_in[QW-2:0], ge};
          rc_t[m+1]   <= t_in;
        end
      end
    end
  endgenerate

  // round R, multiply by t, round the product, apply signs
  logic [TW-1:0]   r_r, r_p, r_o, t_r, p_o;
  logic [2*TW-1:0] prod, prod_rnd;
  logic [DW+F:0]   r_w, p_w;
  logic [DW-1:0]   dir_c, oth_c, cos_o, sin_o;

  assign prod_rnd = prod + (2*TW)'(64'd1 << (F - 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      r_r  <= TW'(((QW+1)'(rc_q[F+2]) + (QW+1)'(1)) >> 1);
      t_r  <= rc_t[F+2];
      prod <= (2*TW)'(r_r) * (2*TW)'(t_r);
      r_p  <= r_r;
      p_o  <= TW'(prod_rnd >> F);
      r_o  <= r_p;
    end
  end

  always_comb begin
    r_w   = (DW+F+1)'(r_o);
    p_w   = (DW+F+1)'(p_o);
    dir_c = r_w[DW-1:0];
    oth_c = ng[LAT-2] ? (~p_w[DW-1:0] + DW'(1)) : p_w[DW-1:0];
    if (triv[LAT-2]) begin
      cos_o = ONE_OUT;
      sin_o = '0;
    end else if (swp[LAT-2]) begin
      cos_o = oth_c;
      sin_o = dir_c;
    end else begin
      cos_o = dir_c;
      sin_o = oth_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= PW'({sin_o, cos_o});
    end
  end

`ifndef SYNTHESIS
  // an accepted request lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted request did not enter the pipeline");

  // a waiting result blocks new requests
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("request taken while result stalled");

  // the directly computed coefficient lies in [0, 1]
  a_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (F <= DW - 2)) |->
      ($signed(swp[LAT-1] ? m_tdata[2*DW-1:DW] : m_tdata[DW-1:0]) >= 0 &&
       $signed(swp[LAT-1] ? m_tdata[2*DW-1:DW] : m_tdata[DW-1:0]) <= $signed(ONE_OUT)))
    else $error("coefficient out of range");
`endif

endmodule
